// ===== src/trqa_pkg.sv =====
// ----------------------------------------------------------------------------
// Task ready-queue arbiter package
// Shared types and constants for the controller, datapath and top level.
// ----------------------------------------------------------------------------
package trqa_pkg;

    localparam int QUEUE_COUNT = 12;
    localparam int QNUM_W      = 4;
    localparam int DISP_W      = 5;
    localparam int CNT_W       = 8;

    // Operation codes of an input item.
    localparam logic OP_ENQUEUE = 1'b0;
    localparam logic OP_CLAIM   = 1'b1;

    // Lanes within one priority.
    localparam logic [1:0] LANE_ANY   = 2'd0;
    localparam logic [1:0] LANE_HEAVY = 2'd1;
    localparam logic [1:0] LANE_LIGHT = 2'd2;
    localparam logic [1:0] LANE_MAIN  = 2'd3;

    // Priorities.
    localparam logic [1:0] PRIO_CRIT = 2'd0;
    localparam logic [1:0] PRIO_NORM = 2'd1;
    localparam logic [1:0] PRIO_BACK = 2'd2;

    // Caller core classes.
    localparam logic [1:0] AFF_ANY  = 2'd0;
    localparam logic [1:0] AFF_PERF = 2'd1;
    localparam logic [1:0] AFF_EFF  = 2'd2;

    // Configuration register indexes.
    localparam logic [1:0] REG_WORKER = 2'd0;
    localparam logic [1:0] REG_PERF   = 2'd1;
    localparam logic [1:0] REG_EFF    = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ENQ_LINK,
        S_ENQ_TAIL,
        S_CLM_SEARCH,
        S_CLM_POP
    } t_state;

    typedef struct packed {
        logic [CNT_W-1:0] worker_count;
        logic [CNT_W-1:0] performance_worker_count;
        logic [CNT_W-1:0] efficiency_worker_count;
    } t_cfg;

    typedef struct packed {
        logic latch_in;
        logic enq_link;
        logic enq_tail;
        logic clm_search;
        logic clm_pop;
        logic res_zero;
    } t_dp_cmd;

    typedef struct packed {
        logic pend_full;
        logic enq_bad;
        logic found;
    } t_dp_sts;

endpackage

// ===== src/task_ready_queue_arbiter.sv =====
// An item is accepted in S_IDLE. The link memory has one write port and a registered read:
// an enqueue writes in S_ENQ_LINK and, unless its queue was empty, in S_ENQ_TAIL; a claim reads
// in S_CLM_SEARCH and writes in S_CLM_POP. A rejected enqueue or a claim that finds nothing
// returns to S_IDLE after its first state. Results pass a pending register, then the output
// register, later while a stalled result holds it; one result may wait there while the next
// item is taken. Reset is synchronous: all queues empty, dispatch count and registers zero.
// ----------------------------------------------------------------------------
// Task ready-queue arbiter
// Twelve linked-list ready queues with aging priority search and claim rules.
// ----------------------------------------------------------------------------
module task_ready_queue_arbiter import trqa_pkg::*; #(
    parameter int MAX_TASKS = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_opcode,
    input  logic [7:0]  i_task_index,
    input  logic [1:0]  i_task_priority,
    input  logic [1:0]  i_task_cost,
    input  logic        i_task_on_main,
    input  logic [1:0]  i_caller_affinity,
    input  logic        i_caller_is_main,
    input  logic        i_caller_cooperative,
    input  logic        i_caller_executing,
    input  logic [7:0]  i_busy_performance,
    input  logic [7:0]  i_busy_efficiency,
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_granted,
    output logic [7:0]  o_granted_index,
    output logic [3:0]  o_granted_queue
);

    t_cfg    r_cfg;
    t_dp_cmd w_cmd;
    t_dp_sts w_sts;
    logic    w_wr;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (w_wr) begin
            case (paddr[3:2])
                REG_WORKER: r_cfg.worker_count             <= pwdata[CNT_W-1:0];
                REG_PERF:   r_cfg.performance_worker_count <= pwdata[CNT_W-1:0];
                REG_EFF:    r_cfg.efficiency_worker_count  <= pwdata[CNT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_WORKER: prdata = 32'(r_cfg.worker_count);
            REG_PERF:   prdata = 32'(r_cfg.performance_worker_count);
            REG_EFF:    prdata = 32'(r_cfg.efficiency_worker_count);
            default:    prdata = '0;
        endcase
    end

    trqa_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .i_opcode (i_opcode),
        .i_sts    (w_sts),
        .o_cmd    (w_cmd),
        .o_stall  (o_stall)
    );

    trqa_dp #(
        .MAX_TASKS (MAX_TASKS)
    ) u_dp (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_cmd                (w_cmd),
        .o_sts                (w_sts),
        .i_cfg                (r_cfg),
        .i_task_index         (i_task_index),
        .i_task_priority      (i_task_priority),
        .i_task_cost          (i_task_cost),
        .i_task_on_main       (i_task_on_main),
        .i_caller_affinity    (i_caller_affinity),
        .i_caller_is_main     (i_caller_is_main),
        .i_caller_cooperative (i_caller_cooperative),
        .i_caller_executing   (i_caller_executing),
        .i_busy_performance   (i_busy_performance),
        .i_busy_efficiency    (i_busy_efficiency),
        .i_stall              (i_stall),
        .o_valid              (o_valid),
        .o_granted            (o_granted),
        .o_granted_index      (o_granted_index),
        .o_granted_queue      (o_granted_queue)
    );

    // The block is busy in the cycle after it takes an item.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_stall)
        else $error("item accepted while previous item still in progress");

    a_pop_after_search: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.clm_pop |-> $past(w_cmd.clm_search))
        else $error("queue popped without a search in the cycle before");

    a_tail_after_link: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.enq_tail |-> $past(w_cmd.enq_link))
        else $error("tail updated without the new link written first");

    a_queue_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_granted) |-> (o_granted_queue < 4'(QUEUE_COUNT)))
        else $error("granted queue number out of range");

endmodule

// ===== src/trqa_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module trqa_ram #(
    parameter int WIDTH = 9,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/trqa_dp.sv =====
// ----------------------------------------------------------------------------
// Task ready-queue arbiter datapath
// Queue head and tail pointers, the next-link memory, the claim search,
// the dispatch counter and the result stages.
// ----------------------------------------------------------------------------
module trqa_dp import trqa_pkg::*; #(
    parameter int MAX_TASKS = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_dp_cmd     i_cmd,
    output t_dp_sts     o_sts,
    input  t_cfg        i_cfg,
    input  logic [7:0]  i_task_index,
    input  logic [1:0]  i_task_priority,
    input  logic [1:0]  i_task_cost,
    input  logic        i_task_on_main,
    input  logic [1:0]  i_caller_affinity,
    input  logic        i_caller_is_main,
    input  logic        i_caller_cooperative,
    input  logic        i_caller_executing,
    input  logic [7:0]  i_busy_performance,
    input  logic [7:0]  i_busy_efficiency,
    input  logic        i_stall,
    output logic        o_valid,
    output logic        o_granted,
    output logic [7:0]  o_granted_index,
    output logic [3:0]  o_granted_queue
);

    localparam int IDX_W = $clog2(MAX_TASKS);
    localparam int PTR_W = $clog2(MAX_TASKS + 1);
    localparam logic [PTR_W-1:0] EMPTY = PTR_W'(MAX_TASKS);

    // Latched item fields.
    logic [7:0]       r_slot;
    logic [1:0]       r_prio;
    logic [1:0]       r_cost;
    logic             r_on_main;
    logic [1:0]       r_aff;
    logic             r_is_main;
    logic             r_coop;
    logic             r_exec;
    logic [7:0]       r_busy_p;
    logic [7:0]       r_busy_e;

    logic [PTR_W-1:0]  r_head [QUEUE_COUNT];
    logic [PTR_W-1:0]  r_tail [QUEUE_COUNT];
    logic [DISP_W-1:0] r_disp;

    logic [QNUM_W-1:0] r_sel_q;
    logic [PTR_W-1:0]  r_sel_h;

    logic              r_pend_valid;
    logic              r_pend_granted;
    logic [7:0]        r_pend_index;
    logic [QNUM_W-1:0] r_pend_queue;
    logic              r_out_valid;
    logic              r_out_granted;
    logic [7:0]        r_out_index;
    logic [QNUM_W-1:0] r_out_queue;

    logic                   w_blocked;
    logic                   w_free;
    logic [3:0]             w_lane_ok;
    logic [QUEUE_COUNT-1:0] w_ready;
    logic [1:0]             w_first;
    logic [1:0]             w_prio_ord [3];
    logic [1:0]             w_lane_ord [4];
    logic [QNUM_W-1:0]      w_pos_q [QUEUE_COUNT];
    logic [QUEUE_COUNT-1:0] w_pos_hit;
    logic                   w_found;
    logic [QNUM_W-1:0]      w_sel_q;
    logic [PTR_W-1:0]       w_sel_h;

    logic [1:0]        w_enq_lane;
    logic [QNUM_W-1:0] w_enq_q;
    logic              w_enq_bad;
    logic [PTR_W-1:0]  w_slot_ptr;
    logic [PTR_W-1:0]  w_tail;
    logic              w_tail_valid;

    logic              w_ram_we;
    logic [IDX_W-1:0]  w_ram_waddr;
    logic [PTR_W-1:0]  w_ram_wdata;
    logic [PTR_W-1:0]  w_ram_rdata;

    logic              w_out_free;
    logic              w_move;

    // Eligibility of each lane for the latched caller.
    always_comb begin
        w_blocked = (r_is_main && (i_cfg.worker_count != '0) && !r_coop)
                  || (!r_is_main && !r_exec);
        w_free    = r_coop || (r_aff == AFF_ANY);
        w_lane_ok[LANE_MAIN]  = r_is_main;
        w_lane_ok[LANE_ANY]   = !w_blocked;
        w_lane_ok[LANE_HEAVY] = !w_blocked && (w_free || (r_aff == AFF_PERF)
                                || (r_busy_p >= i_cfg.performance_worker_count));
        w_lane_ok[LANE_LIGHT] = !w_blocked && (w_free || (r_aff == AFF_EFF)
                                || (r_busy_e >= i_cfg.efficiency_worker_count));
    end

    always_comb begin
        for (int q = 0; q < QUEUE_COUNT; q++) begin
            w_ready[q] = r_head[q] < EMPTY;
        end
    end

    // Aging picks the first priority; the others follow in ascending order.
    always_comb begin
        if (&r_disp) begin
            w_first = PRIO_BACK;
        end else if (&r_disp[2:0]) begin
            w_first = PRIO_NORM;
        end else begin
            w_first = PRIO_CRIT;
        end
        w_prio_ord[0] = w_first;
        w_prio_ord[1] = (w_first == PRIO_CRIT) ? PRIO_NORM : PRIO_CRIT;
        w_prio_ord[2] = (w_first == PRIO_BACK) ? PRIO_NORM : PRIO_BACK;
        w_lane_ord[0] = LANE_MAIN;
        w_lane_ord[1] = (r_aff == AFF_EFF) ? LANE_LIGHT : LANE_HEAVY;
        w_lane_ord[2] = LANE_ANY;
        w_lane_ord[3] = (r_aff == AFF_EFF) ? LANE_HEAVY : LANE_LIGHT;
    end

    // Each search position is tested on its own, then the earliest hit wins.
    always_comb begin
        for (int p = 0; p < 3; p++) begin
            for (int l = 0; l < 4; l++) begin
                w_pos_q[p*4+l]   = {w_prio_ord[p], w_lane_ord[l]};
                w_pos_hit[p*4+l] = w_ready[w_pos_q[p*4+l]] && w_lane_ok[w_lane_ord[l]];
            end
        end
        w_found = 1'b0;
        w_sel_q = '0;
        for (int pos = QUEUE_COUNT - 1; pos >= 0; pos--) begin
            if (w_pos_hit[pos]) begin
                w_found = 1'b1;
                w_sel_q = w_pos_q[pos];
            end
        end
        w_sel_h = r_head[w_sel_q];
    end

    always_comb begin
        w_enq_lane   = r_on_main ? LANE_MAIN : r_cost;
        w_enq_q      = {r_prio, w_enq_lane};
        w_enq_bad    = (r_prio > PRIO_BACK) || (!r_on_main && (r_cost > LANE_LIGHT))
                     || (32'(r_slot) >= 32'(MAX_TASKS));
        w_slot_ptr   = PTR_W'(r_slot);
        w_tail       = r_tail[w_enq_q];
        w_tail_valid = w_tail < EMPTY;
    end

    // The link memory has one write port: an enqueue uses it twice, or once into an empty queue; a claim once.
    always_comb begin
        w_ram_we = i_cmd.enq_link || (i_cmd.enq_tail && w_tail_valid) || i_cmd.clm_pop;
        if (i_cmd.enq_link) begin
            w_ram_waddr = IDX_W'(r_slot);
        end else if (i_cmd.enq_tail) begin
            w_ram_waddr = w_tail[IDX_W-1:0];
        end else begin
            w_ram_waddr = r_sel_h[IDX_W-1:0];
        end
        w_ram_wdata = i_cmd.enq_tail ? w_slot_ptr : EMPTY;
    end

    trqa_ram #(
        .WIDTH (PTR_W),
        .DEPTH (MAX_TASKS)
    ) u_link_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_ram_waddr),
        .i_wdata (w_ram_wdata),
        .i_raddr (w_sel_h[IDX_W-1:0]),
        .o_rdata (w_ram_rdata)
    );

    assign w_out_free = !r_out_valid || !i_stall;
    assign w_move     = r_pend_valid && w_out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int q = 0; q < QUEUE_COUNT; q++) begin
                r_head[q] <= EMPTY;
                r_tail[q] <= EMPTY;
            end
            r_disp       <= '0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cmd.enq_tail) begin
                if (!w_tail_valid) begin
                    r_head[w_enq_q] <= w_slot_ptr;
                end
                r_tail[w_enq_q] <= w_slot_ptr;
            end
            if (i_cmd.clm_pop) begin
                r_head[r_sel_q] <= w_ram_rdata;
                if (r_tail[r_sel_q] == r_sel_h) begin
                    r_tail[r_sel_q] <= EMPTY;
                end
                r_disp <= r_disp + 1'b1;
            end
            if (i_cmd.res_zero || i_cmd.clm_pop) begin
                r_pend_valid <= 1'b1;
            end else if (w_move) begin
                r_pend_valid <= 1'b0;
            end
            if (w_move) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch_in) begin
            r_slot    <= i_task_index;
            r_prio    <= i_task_priority;
            r_cost    <= i_task_cost;
            r_on_main <= i_task_on_main;
            r_aff     <= i_caller_affinity;
            r_is_main <= i_caller_is_main;
            r_coop    <= i_caller_cooperative;
            r_exec    <= i_caller_executing;
            r_busy_p  <= i_busy_performance;
            r_busy_e  <= i_busy_efficiency;
        end
        if (i_cmd.clm_search) begin
            r_sel_q <= w_sel_q;
            r_sel_h <= w_sel_h;
        end
        if (i_cmd.res_zero) begin
            r_pend_granted <= 1'b0;
            r_pend_index   <= '0;
            r_pend_queue   <= '0;
        end else if (i_cmd.clm_pop) begin
            r_pend_granted <= 1'b1;
            r_pend_index   <= 8'(r_sel_h);
            r_pend_queue   <= r_sel_q;
        end
        if (w_move) begin
            r_out_granted <= r_pend_granted;
            r_out_index   <= r_pend_index;
            r_out_queue   <= r_pend_queue;
        end
    end

    assign o_sts.pend_full = r_pend_valid && !w_out_free;
    assign o_sts.enq_bad   = w_enq_bad;
    assign o_sts.found     = w_found;

    assign o_valid         = r_out_valid;
    assign o_granted       = r_out_granted;
    assign o_granted_index = r_out_index;
    assign o_granted_queue = r_out_queue;

endmodule

// ===== src/trqa_ctrl.sv =====
// ----------------------------------------------------------------------------
// Task ready-queue arbiter controller
// Sequences enqueue and claim operations over the datapath.
// ----------------------------------------------------------------------------
module trqa_ctrl import trqa_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    input  logic    i_opcode,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd,
    output logic    o_stall
);

    t_state r_state;
    t_state n_state;
    logic   w_accept;

    assign w_accept = (r_state == S_IDLE) && i_valid && !i_sts.pend_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = (i_opcode == OP_CLAIM) ? S_CLM_SEARCH : S_ENQ_LINK;
                end
            end
            S_ENQ_LINK: begin
                n_state = i_sts.enq_bad ? S_IDLE : S_ENQ_TAIL;
            end
            S_ENQ_TAIL: begin
                n_state = S_IDLE;
            end
            S_CLM_SEARCH: begin
                n_state = i_sts.found ? S_CLM_POP : S_IDLE;
            end
            S_CLM_POP: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd          = '0;
        o_cmd.latch_in = w_accept;
        o_stall        = (r_state != S_IDLE) || i_sts.pend_full;
        case (r_state)
            S_IDLE: begin
                o_cmd.latch_in = w_accept;
            end
            S_ENQ_LINK: begin
                o_cmd.enq_link = !i_sts.enq_bad;
                o_cmd.res_zero = i_sts.enq_bad;
            end
            S_ENQ_TAIL: begin
                o_cmd.enq_tail = 1'b1;
                o_cmd.res_zero = 1'b1;
            end
            S_CLM_SEARCH: begin
                o_cmd.clm_search = 1'b1;
                o_cmd.res_zero   = !i_sts.found;
            end
            S_CLM_POP: begin
                o_cmd.clm_pop = 1'b1;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule
